// File: hdl/lfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log frame deframer package
// Shared constants, codes and types of the log frame deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int COUNT_W     = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 26;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_LVL_W  = 3;

  // Byte positions of the frame fields.
  localparam int MAGIC_END    = 4;
  localparam int VERSION_POS  = 4;
  localparam int TYPE_POS     = 5;
  localparam int RESERVED_END = 8;
  localparam int HEADER_BYTES = 12;
  localparam int FIELD_BYTES  = 8 + 8 + 4 + 4;
  localparam int ID_END       = HEADER_BYTES + 8;
  localparam int TIME_END     = HEADER_BYTES + 16;
  localparam int SRC_END      = HEADER_BYTES + 20;
  localparam int BODY_BYTES   = HEADER_BYTES + FIELD_BYTES;

  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VERSION     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOG_TYPE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TYPE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SOURCE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CONTENT = 3'd5;

  localparam logic [1:0] KIND_SOURCE  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_OUTCOME = 2'd2;

  localparam logic [3:0] ST_OK              = 4'd0;
  localparam logic [3:0] ST_TRUNCATED       = 4'd1;
  localparam logic [3:0] ST_UNKNOWN_TYPE    = 4'd2;
  localparam logic [3:0] ST_MAGIC           = 4'd3;
  localparam logic [3:0] ST_VERSION         = 4'd4;
  localparam logic [3:0] ST_RESERVED        = 4'd5;
  localparam logic [3:0] ST_TOO_LARGE       = 4'd6;
  localparam logic [3:0] ST_NOT_LOG         = 4'd7;
  localparam logic [3:0] ST_LENGTH_MISMATCH = 4'd8;
  localparam logic [3:0] ST_SOURCE_LONG     = 4'd9;
  localparam logic [3:0] ST_CONTENT_LONG    = 4'd10;
  localparam logic [3:0] ST_FIELDS_MISMATCH = 4'd11;

  localparam logic [31:0] MAGIC_RESET       = 32'd0;
  localparam logic [7:0]  VERSION_RESET     = 8'd0;
  localparam logic [7:0]  LOG_TYPE_RESET    = 8'd0;
  localparam logic [7:0]  ACK_TYPE_RESET    = 8'd1;
  localparam logic [23:0] MAX_SOURCE_RESET  = 24'd65535;
  localparam logic [23:0] MAX_CONTENT_RESET = 24'd65535;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [7:0]  version_value;
    logic [7:0]  log_type_code;
    logic [7:0]  ack_type_code;
    logic [23:0] max_source_bytes;
    logic [23:0] max_content_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         item_kind;
    logic [7:0]         out_byte;
    logic [3:0]         status;
    logic [63:0]        message_id;
    logic signed [63:0] timestamp_ms;
    logic [31:0]        source_bytes;
    logic [31:0]        content_bytes;
    logic               last_of_step;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic [FIFO_LVL_W-1:0] level;
    logic                  room2;
  } fifo_stat_t;

endpackage

// File: hdl/lfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log frame deframer channels
// Byte input channel and result output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface lfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [7:0]         out_byte;
  logic [3:0]         status;
  logic [63:0]        message_id;
  logic signed [63:0] timestamp_ms;
  logic [31:0]        source_bytes;
  logic [31:0]        content_bytes;
  logic               last_of_step;

  modport source (
    output valid, output item_kind, output out_byte, output status,
    output message_id, output timestamp_ms, output source_bytes,
    output content_bytes, output last_of_step, input ready
  );
  modport sink (
    input valid, input item_kind, input out_byte, input status,
    input message_id, input timestamp_ms, input source_bytes,
    input content_bytes, input last_of_step, output ready
  );
endinterface

// File: hdl/log_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log frame deframer core
// Parses a byte stream of log frames, streams string bytes and reports one
// outcome word per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle while the output queue has
// room. An accepted byte is held in the input register, is parsed in a single
// pass and its result words go into a four-entry output queue, from which the
// first word is handed out. A byte gives no word, one word, or two
// words when the frame's last byte is also a string byte, and the queue hands
// out one word per cycle while the result is taken; input stalls only while
// the queue holds more than two words. Configuration writes are registered
// before use and must be made while no frame is in flight.
module log_frame_deframer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lfd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  lfd_byte_if.sink                            byte_i,
  lfd_result_if.source                        result_o
);

  lfd_pkg::cfg_t       cfg_q, cfg_d;
  logic                in_vld_q, in_vld_d;
  logic [7:0]          in_byte_q;
  logic                in_end_q;
  logic                proc_fire;
  lfd_pkg::push_t      push;
  lfd_pkg::fifo_stat_t fifo_stat;
  lfd_pkg::result_t    res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lfd_pkg::REG_MAGIC:       cfg_d.magic_value       = cfg_wdata_i;
        lfd_pkg::REG_VERSION:     cfg_d.version_value     = cfg_wdata_i[7:0];
        lfd_pkg::REG_LOG_TYPE:    cfg_d.log_type_code     = cfg_wdata_i[7:0];
        lfd_pkg::REG_ACK_TYPE:    cfg_d.ack_type_code     = cfg_wdata_i[7:0];
        lfd_pkg::REG_MAX_SOURCE:  cfg_d.max_source_bytes  = cfg_wdata_i[23:0];
        lfd_pkg::REG_MAX_CONTENT: cfg_d.max_content_bytes = cfg_wdata_i[23:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_value       <= lfd_pkg::MAGIC_RESET;
      cfg_q.version_value     <= lfd_pkg::VERSION_RESET;
      cfg_q.log_type_code     <= lfd_pkg::LOG_TYPE_RESET;
      cfg_q.ack_type_code     <= lfd_pkg::ACK_TYPE_RESET;
      cfg_q.max_source_bytes  <= lfd_pkg::MAX_SOURCE_RESET;
      cfg_q.max_content_bytes <= lfd_pkg::MAX_CONTENT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign proc_fire    = in_vld_q && fifo_stat.room2;
  assign byte_i.ready = !in_vld_q || proc_fire;

  always_comb begin
    in_vld_d = in_vld_q;
    if (byte_i.ready) begin
      in_vld_d = byte_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_end_q  <= byte_i.frame_end;
    end
  end

  lfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (proc_fire),
    .data_byte_i (in_byte_q),
    .frame_end_i (in_end_q),
    .cfg_i       (cfg_q),
    .push_o      (push)
  );

  lfd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_ready_i (result_o.ready),
    .pop_valid_o (result_o.valid),
    .pop_data_o  (res),
    .stat_o      (fifo_stat)
  );

  assign result_o.item_kind     = res.item_kind;
  assign result_o.out_byte      = res.out_byte;
  assign result_o.status        = res.status;
  assign result_o.message_id    = res.message_id;
  assign result_o.timestamp_ms  = res.timestamp_ms;
  assign result_o.source_bytes  = res.source_bytes;
  assign result_o.content_bytes = res.content_bytes;
  assign result_o.last_of_step  = res.last_of_step;

  // A held byte stays put until the queue has room for its words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc_fire) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_end_q)))
    else $error("Input register changed while the byte was stalled.");

  // The last byte of a frame always leaves an outcome word in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && in_end_q) |=> result_o.valid)
    else $error("Frame end produced no outcome word.");

  // The queue never holds more words than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.level <= lfd_pkg::FIFO_LVL_W'(lfd_pkg::FIFO_DEPTH))
    else $error("Result queue overflow.");

endmodule

// File: hdl/lfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log frame deframer parser
// Shifts header and fixed payload fields in, classifies string bytes and
// evaluates the frame checks on the last byte of a frame.
// ----------------------------------------------------------------------------
module lfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  input  lfd_pkg::cfg_t       cfg_i,
  output lfd_pkg::push_t      push_o
);

  logic [lfd_pkg::COUNT_W-1:0] count_q, count_d, count_upd;
  logic [31:0]                 magic_q, magic_d, magic_upd;
  logic [7:0]                  version_q, version_d, version_upd;
  logic [7:0]                  type_q, type_d, type_upd;
  logic [15:0]                 reserved_q, reserved_d, reserved_upd;
  logic [31:0]                 paylen_q, paylen_d, paylen_upd;
  logic [63:0]                 id_q, id_d, id_upd;
  logic [63:0]                 time_q, time_d, time_upd;
  logic [31:0]                 srclen_q, srclen_d, srclen_upd;
  logic [31:0]                 cntlen_q, cntlen_d, cntlen_upd;
  logic [lfd_pkg::LIMIT_W-1:0] limit_q, limit_d;

  logic [lfd_pkg::COUNT_W-1:0] pos;
  logic [lfd_pkg::COUNT_W-1:0] rel;
  logic [lfd_pkg::COUNT_W:0]   str_total;
  logic                        in_strings;
  logic                        is_source;
  logic                        is_content;
  logic                        has_str;
  logic [3:0]                  status;
  lfd_pkg::result_t            str_item;
  lfd_pkg::result_t            outcome;

  assign pos       = count_q;
  assign rel       = pos - lfd_pkg::COUNT_W'(lfd_pkg::BODY_BYTES);
  assign str_total = {2'b00, srclen_q} + {2'b00, cntlen_q};
  assign limit_d   = lfd_pkg::LIMIT_W'(lfd_pkg::FIELD_BYTES)
                   + lfd_pkg::LIMIT_W'(cfg_i.max_source_bytes)
                   + lfd_pkg::LIMIT_W'(cfg_i.max_content_bytes);

  always_comb begin
    magic_upd    = magic_q;
    version_upd  = version_q;
    type_upd     = type_q;
    reserved_upd = reserved_q;
    paylen_upd   = paylen_q;
    id_upd       = id_q;
    time_upd     = time_q;
    srclen_upd   = srclen_q;
    cntlen_upd   = cntlen_q;
    in_strings   = 1'b0;
    if (pos < lfd_pkg::COUNT_W'(lfd_pkg::MAGIC_END)) begin
      magic_upd = {magic_q[23:0], data_byte_i};
    end else if (pos == lfd_pkg::COUNT_W'(lfd_pkg::VERSION_POS)) begin
      version_upd = data_byte_i;
    end else if (pos == lfd_pkg::COUNT_W'(lfd_pkg::TYPE_POS)) begin
      type_upd = data_byte_i;
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::RESERVED_END)) begin
      reserved_upd = {reserved_q[7:0], data_byte_i};
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::HEADER_BYTES)) begin
      paylen_upd = {paylen_q[23:0], data_byte_i};
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::ID_END)) begin
      id_upd = {id_q[55:0], data_byte_i};
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::TIME_END)) begin
      time_upd = {time_q[55:0], data_byte_i};
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::SRC_END)) begin
      srclen_upd = {srclen_q[23:0], data_byte_i};
    end else if (pos < lfd_pkg::COUNT_W'(lfd_pkg::BODY_BYTES)) begin
      cntlen_upd = {cntlen_q[23:0], data_byte_i};
    end else begin
      in_strings = 1'b1;
    end
    count_upd = (pos == '1) ? pos : pos + lfd_pkg::COUNT_W'(1);
  end

  assign is_source  = in_strings && (rel < {1'b0, srclen_q});
  assign is_content = in_strings && !is_source && ({1'b0, rel} < str_total);
  assign has_str    = is_source || is_content;

  // The checks run in a fixed order and the first failing one sets the code.
  always_comb begin
    if (count_upd < lfd_pkg::COUNT_W'(lfd_pkg::HEADER_BYTES)) begin
      status = lfd_pkg::ST_TRUNCATED;
    end else if (type_upd != cfg_i.log_type_code && type_upd != cfg_i.ack_type_code) begin
      status = lfd_pkg::ST_UNKNOWN_TYPE;
    end else if (magic_upd != cfg_i.magic_value) begin
      status = lfd_pkg::ST_MAGIC;
    end else if (version_upd != cfg_i.version_value) begin
      status = lfd_pkg::ST_VERSION;
    end else if (reserved_upd != 16'd0) begin
      status = lfd_pkg::ST_RESERVED;
    end else if (paylen_upd > {6'd0, limit_q}) begin
      status = lfd_pkg::ST_TOO_LARGE;
    end else if (type_upd != cfg_i.log_type_code) begin
      status = lfd_pkg::ST_NOT_LOG;
    end else if (count_upd != lfd_pkg::COUNT_W'(lfd_pkg::HEADER_BYTES)
                              + {1'b0, paylen_upd}) begin
      status = lfd_pkg::ST_LENGTH_MISMATCH;
    end else if (paylen_upd < 32'(lfd_pkg::FIELD_BYTES)) begin
      status = lfd_pkg::ST_TRUNCATED;
    end else if (srclen_upd > {8'd0, cfg_i.max_source_bytes}) begin
      status = lfd_pkg::ST_SOURCE_LONG;
    end else if (cntlen_upd > {8'd0, cfg_i.max_content_bytes}) begin
      status = lfd_pkg::ST_CONTENT_LONG;
    end else if ({2'b00, paylen_upd} != 34'(lfd_pkg::FIELD_BYTES)
                 + {2'b00, srclen_upd} + {2'b00, cntlen_upd}) begin
      status = lfd_pkg::ST_FIELDS_MISMATCH;
    end else begin
      status = lfd_pkg::ST_OK;
    end
  end

  always_comb begin
    str_item              = '0;
    str_item.item_kind    = is_source ? lfd_pkg::KIND_SOURCE : lfd_pkg::KIND_CONTENT;
    str_item.out_byte     = data_byte_i;
    str_item.last_of_step = !frame_end_i;

    outcome               = '0;
    outcome.item_kind     = lfd_pkg::KIND_OUTCOME;
    outcome.status        = status;
    outcome.message_id    = id_upd;
    outcome.timestamp_ms  = time_upd;
    outcome.source_bytes  = srclen_upd;
    outcome.content_bytes = cntlen_upd;
    outcome.last_of_step  = 1'b1;

    push_o.count  = fire_i ? ({1'b0, has_str} + {1'b0, frame_end_i}) : 2'd0;
    push_o.first  = has_str ? str_item : outcome;
    push_o.second = outcome;
  end

  always_comb begin
    count_d    = count_q;
    magic_d    = magic_q;
    version_d  = version_q;
    type_d     = type_q;
    reserved_d = reserved_q;
    paylen_d   = paylen_q;
    id_d       = id_q;
    time_d     = time_q;
    srclen_d   = srclen_q;
    cntlen_d   = cntlen_q;
    if (fire_i) begin
      if (frame_end_i) begin
        count_d    = '0;
        magic_d    = '0;
        version_d  = '0;
        type_d     = '0;
        reserved_d = '0;
        paylen_d   = '0;
        id_d       = '0;
        time_d     = '0;
        srclen_d   = '0;
        cntlen_d   = '0;
      end else begin
        count_d    = count_upd;
        magic_d    = magic_upd;
        version_d  = version_upd;
        type_d     = type_upd;
        reserved_d = reserved_upd;
        paylen_d   = paylen_upd;
        id_d       = id_upd;
        time_d     = time_upd;
        srclen_d   = srclen_upd;
        cntlen_d   = cntlen_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      magic_q    <= '0;
      version_q  <= '0;
      type_q     <= '0;
      reserved_q <= '0;
      paylen_q   <= '0;
      id_q       <= '0;
      time_q     <= '0;
      srclen_q   <= '0;
      cntlen_q   <= '0;
      limit_q    <= '0;
    end else begin
      count_q    <= count_d;
      magic_q    <= magic_d;
      version_q  <= version_d;
      type_q     <= type_d;
      reserved_q <= reserved_d;
      paylen_q   <= paylen_d;
      id_q       <= id_d;
      time_q     <= time_d;
      srclen_q   <= srclen_d;
      cntlen_q   <= cntlen_d;
      limit_q    <= limit_d;
    end
  end

endmodule

// File: hdl/lfd_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log frame deframer result queue
// Four-entry queue that takes up to two result words per cycle and hands out
// one word per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module lfd_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfd_pkg::push_t      push_i,
  input  logic                pop_ready_i,
  output logic                pop_valid_o,
  output lfd_pkg::result_t    pop_data_o,
  output lfd_pkg::fifo_stat_t stat_o
);

  lfd_pkg::result_t                 mem_q [lfd_pkg::FIFO_DEPTH];
  logic [lfd_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lfd_pkg::FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lfd_pkg::FIFO_LVL_W-1:0]   level_q, level_d;
  logic [lfd_pkg::FIFO_PTR_W-1:0]   wr_ptr_next;
  logic                             pop;

  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_valid_o  = (level_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign wr_ptr_next  = wr_ptr_q + lfd_pkg::FIFO_PTR_W'(1);
  assign stat_o.level = level_q;
  assign stat_o.room2 = (level_q <= lfd_pkg::FIFO_LVL_W'(lfd_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + lfd_pkg::FIFO_PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + lfd_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    level_d  = level_q + lfd_pkg::FIFO_LVL_W'(push_i.count)
             - lfd_pkg::FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule
